/* rtl/rgf_pkg.sv */
// Shared types and constants of the radial Gaussian falloff texel unit.
package rgf_pkg;

  // Fixed-point units.
  localparam int Q16_ONE = 65536;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [61:0] Q30_HALF = 62'h2000_0000;
  localparam logic [31:0] Q14_HALF = 32'd8192;
  localparam int OUT_MAX = 255;

  // Reciprocal of six for the cubic term of the series, exact below 2^21.
  localparam logic [19:0] DIV6_MUL = 20'd699051;
  localparam int DIV6_SHIFT = 22;

  // Configuration register indexes and reset values.
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_NEAR = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_FAR = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGMA_NEAR = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGMA_FAR = 8'd3;
  localparam logic [15:0] RST_OFFSET_NEAR = 16'd3277;
  localparam logic [15:0] RST_OFFSET_FAR = 16'd13107;
  localparam logic [15:0] RST_SIGMA_NEAR = 16'd1311;
  localparam logic [15:0] RST_SIGMA_FAR = 16'd32768;

  // Stage counts of the pipelined units.
  localparam int SQRT_STAGES = 17;
  localparam int DIV_STEPS = 21;
  localparam int SQUARINGS = 8;
  localparam int GAUSS_STAGES = 1 + DIV_STEPS + 4 + SQUARINGS + 1;
  localparam int RATIO_STAGES = 8;

  // How the final intensity is formed.
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_FULL,
    KIND_DIV
  } ratio_kind_t;

endpackage

/* rtl/radial_gaussian_falloff_texel_unit.sv */
// Top level of the radial Gaussian falloff texel unit.
// One texel word (col, row, slice) enters and its 8-bit intensity leaves through
// the input, lookup, interpolation and square stages (4), the one-bit-per-stage
// square root (17), the distance stage (1), the Gaussian pipeline of squares, a
// 21-step divider, series, eight squarings and rounding (35), the compare stage (1)
// and the 8-step quotient (8). Throughput is one texel per clock while the output
// skid register is empty; that one-word register catches a finished word the sink
// did not take, and the pipeline stalls and in_ready drops only while it is full.
// Configuration writes are taken in any cycle and must be made while no
// texel is in flight.
module radial_gaussian_falloff_texel_unit import rgf_pkg::*; #(
  parameter int TEX_WIDTH  = 256,
  parameter int TEX_HEIGHT = 256,
  parameter int TEX_DEPTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             col,
  input  logic [7:0]             row,
  input  logic [3:0]             slice,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             intensity,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int DEPTH_SPAN   = TEX_DEPTH - 1;
  localparam int WB           = $clog2(TEX_DEPTH);
  localparam int NW           = 16 + WB;
  localparam int MW           = 19 + WB;
  localparam int LERP_SHIFT   = 17 + 2 * WB;
  localparam longint unsigned LERP_MUL_L =
    ((64'd1 << LERP_SHIFT) + 64'(DEPTH_SPAN) - 64'd1) / 64'(DEPTH_SPAN);
  localparam logic [MW-1:0] LERP_MUL = MW'(LERP_MUL_L);
  localparam int ALIGN_STAGES = 1 + SQRT_STAGES;
  localparam int PIPE_STAGES  = 4 + SQRT_STAGES + 1 + GAUSS_STAGES + 1 + RATIO_STAGES;

  logic en;

  // Configuration registers.
  logic [15:0] off_near, off_far, sig_near, sig_far;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      off_near <= RST_OFFSET_NEAR;
      off_far  <= RST_OFFSET_FAR;
      sig_near <= RST_SIGMA_NEAR;
      sig_far  <= RST_SIGMA_FAR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_NEAR: off_near <= cfg_data;
        REG_OFFSET_FAR:  off_far  <= cfg_data;
        REG_SIGMA_NEAR:  sig_near <= cfg_data;
        REG_SIGMA_FAR:   sig_far  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Axis magnitude tables, index saturated to the volume and mapped to [-1,1].
  logic [16:0] x_mag_tab [256];
  logic [16:0] y_mag_tab [256];
  for (genvar i = 0; i < 256; i++) begin : g_axis
    localparam int CX = (i > TEX_WIDTH - 1) ? TEX_WIDTH - 1 : i;
    localparam int CY = (i > TEX_HEIGHT - 1) ? TEX_HEIGHT - 1 : i;
    localparam int VX = (2 * CX * Q16_ONE) / (TEX_WIDTH - 1) - Q16_ONE;
    localparam int VY = (2 * CY * Q16_ONE) / (TEX_HEIGHT - 1) - Q16_ONE;
    assign x_mag_tab[i] = 17'((VX < 0) ? -VX : VX);
    assign y_mag_tab[i] = 17'((VY < 0) ? -VY : VY);
  end

  // Stage 1: input word, slice saturated to the last slice.
  logic [7:0]    s1_col, s1_row;
  logic [WB-1:0] s1_slice;
  logic [WB-1:0] slice_sat;
  assign slice_sat = (int'(slice) > DEPTH_SPAN) ? WB'(DEPTH_SPAN) : WB'(slice);
  always_ff @(posedge clk) begin
    if (en) begin
      s1_col   <= col;
      s1_row   <= row;
      s1_slice <= slice_sat;
    end
  end

  // Stage 2: axis lookups and weighted sums of the near and far registers.
  logic [16:0]   s2_xmag, s2_ymag;
  logic [NW-1:0] s2_off_num, s2_sig_num;
  logic [WB-1:0] w_near;
  assign w_near = WB'(DEPTH_SPAN) - s1_slice;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_xmag    <= x_mag_tab[s1_col];
      s2_ymag    <= y_mag_tab[s1_row];
      s2_off_num <= NW'(off_near) * NW'(w_near) + NW'(off_far) * NW'(s1_slice);
      s2_sig_num <= NW'(sig_near) * NW'(w_near) + NW'(sig_far) * NW'(s1_slice);
    end
  end

  // Stage 3: squares of the axes and division of the sums by the slice span.
  logic [33:0]      s3_xsq, s3_ysq;
  logic [15:0]      s3_off, s3_sig;
  logic [NW+MW-1:0] off_prod, sig_prod;
  assign off_prod = (NW + MW)'(s2_off_num) * (NW + MW)'(LERP_MUL);
  assign sig_prod = (NW + MW)'(s2_sig_num) * (NW + MW)'(LERP_MUL);
  always_ff @(posedge clk) begin
    if (en) begin
      s3_xsq <= 34'(s2_xmag) * 34'(s2_xmag);
      s3_ysq <= 34'(s2_ymag) * 34'(s2_ymag);
      s3_off <= 16'(off_prod >> LERP_SHIFT);
      s3_sig <= 16'(sig_prod >> LERP_SHIFT);
    end
  end

  // Stage 4: squared radius.
  logic [33:0] s4_rsq;
  always_ff @(posedge clk) begin
    if (en) s4_rsq <= s3_xsq + s3_ysq;
  end

  // Radius, with offset and sigma held back to meet it.
  logic [16:0] r_root;
  logic [15:0] a_off, a_sig;
  logic        a_sig_zero;
  rgf_isqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s4_rsq),
    .root     (r_root)
  );
  rgf_delay #(.WIDTH(33), .DEPTH(ALIGN_STAGES)) u_align (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  ({s3_sig == 16'd0, s3_off, s3_sig}),
    .dout ({a_sig_zero, a_off, a_sig})
  );

  // Distance stage: ring, edge and peak distances.
  logic signed [17:0] ring_delta;
  logic        [17:0] ring_delta_abs;
  logic [16:0] d_mag_ring, d_mag_bias, d_mag_peak;
  logic [15:0] d_sig;
  logic        d_sig_zero;
  assign ring_delta     = signed'({1'b0, r_root}) - signed'({2'b00, a_off});
  assign ring_delta_abs = ring_delta[17] ? 18'(-ring_delta) : 18'(ring_delta);
  always_ff @(posedge clk) begin
    if (en) begin
      d_mag_ring <= 17'(ring_delta_abs);
      d_mag_bias <= 17'(Q16_ONE) - 17'(a_off);
      d_mag_peak <= {1'b0, a_off};
      d_sig      <= a_sig;
      d_sig_zero <= a_sig_zero;
    end
  end

  // Three Gaussians in parallel.
  logic [16:0] g_ring, g_bias, g_peak;
  logic        g_sig_zero;
  rgf_gauss u_gauss_ring (.clk(clk), .en(en), .mag(d_mag_ring), .sigma(d_sig), .gval(g_ring));
  rgf_gauss u_gauss_bias (.clk(clk), .en(en), .mag(d_mag_bias), .sigma(d_sig), .gval(g_bias));
  rgf_gauss u_gauss_peak (.clk(clk), .en(en), .mag(d_mag_peak), .sigma(d_sig), .gval(g_peak));
  rgf_delay #(.WIDTH(1), .DEPTH(GAUSS_STAGES)) u_zero_dly (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (d_sig_zero),
    .dout (g_sig_zero)
  );

  // Compare stage: peak amplitude, value above the edge, and the case to apply.
  logic signed [17:0] amp, val;
  ratio_kind_t kind_c, f_kind;
  logic [23:0] f_num;
  logic [16:0] f_den;
  assign amp = signed'({1'b0, g_peak}) - signed'({1'b0, g_bias});
  assign val = signed'({1'b0, g_ring}) - signed'({1'b0, g_bias});
  always_comb begin
    priority if (g_sig_zero || amp <= 0 || val <= 0) kind_c = KIND_ZERO;
    else if (val >= amp)                            kind_c = KIND_FULL;
    else                                            kind_c = KIND_DIV;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_kind <= kind_c;
      f_num  <= 24'(val[16:0]) * 24'(OUT_MAX);
      f_den  <= amp[16:0];
    end
  end

  logic [7:0] pipe_level;
  rgf_ratio u_ratio (
    .clk   (clk),
    .en    (en),
    .kind  (f_kind),
    .num   (f_num),
    .den   (f_den),
    .level (pipe_level)
  );

  // Valid bits of the whole pipeline.
  logic pipe_valid;
  rgf_delay #(.WIDTH(1), .DEPTH(PIPE_STAGES)) u_valid (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (in_valid),
    .dout (pipe_valid)
  );

  // Output skid register: holds a word the sink did not take.
  logic       skid_full;
  logic [7:0] skid_level;
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) skid_full <= 1'b0;
    end else if (pipe_valid && !out_ready) begin
      skid_full <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!skid_full && pipe_valid && !out_ready) skid_level <= pipe_level;
  end

  assign en        = !skid_full;
  assign in_ready  = en;
  assign out_valid = skid_full || pipe_valid;
  assign intensity = skid_full ? skid_level : pipe_level;

endmodule

/* rtl/rgf_delay.sv */
// Enabled shift line that carries a word a fixed number of stages.
module rgf_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  // Shift one place on every enabled cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else if (en) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule

/* rtl/rgf_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module rgf_isqrt import rgf_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [33:0] radicand,
  output logic [16:0] root
);

  logic [33:0] rem_q  [SQRT_STAGES-1];
  logic [16:0] root_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
    localparam int B = SQRT_STAGES - 1 - k;
    logic [33:0] rem_in;
    logic [16:0] root_in;
    logic [34:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Setting this bit grows the square by 2*root*2^B + 2^(2B).
    assign trial = (35'(root_in) << (B + 1)) + (35'(1) << (2 * B));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= take ? (root_in | (17'(1) << B)) : root_in;
      end
    end

    if (k < SQRT_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? 34'({1'b0, rem_in} - trial) : rem_in;
        end
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

/* rtl/rgf_gauss.sv */
// Pipelined Gaussian exp(-d^2/(2 s^2)) in Q16 from a distance and a width.
module rgf_gauss import rgf_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] mag,
  input  logic [15:0] sigma,
  output logic [16:0] gval
);

  // Squares of distance and width.
  logic [33:0] msq;
  logic [31:0] ssq;
  always_ff @(posedge clk) begin
    if (en) begin
      msq <= 34'(mag) * 34'(mag);
      ssq <= 32'(sigma) * 32'(sigma);
    end
  end

  // Restoring division d^2*2^16 / (2 s^2), top bit flags an exponent of 16 or more.
  logic [49:0]          drem [DIV_STEPS-1];
  logic [32:0]          dden [DIV_STEPS-1];
  logic [DIV_STEPS-1:0] dquo [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    logic [49:0]          rem_in;
    logic [32:0]          den_in;
    logic [DIV_STEPS-1:0] quo_in;
    logic [52:0]          shifted;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = {msq, 16'd0};
      assign den_in = {ssq, 1'b0};
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = drem[k-1];
      assign den_in = dden[k-1];
      assign quo_in = dquo[k-1];
    end

    assign shifted = 53'(den_in) << B;
    assign ge      = 53'(rem_in) >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        dquo[k] <= quo_in | (DIV_STEPS'(ge) << B);
      end
    end

    if (k < DIV_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          drem[k] <= ge ? 50'(53'(rem_in) - shifted) : rem_in;
          dden[k] <= den_in;
        end
      end
    end
  end

  logic        div_sat;
  logic [25:0] t0;
  assign div_sat = dquo[DIV_STEPS-1][DIV_STEPS-1];
  assign t0      = {dquo[DIV_STEPS-1][DIV_STEPS-2:0], 6'd0};

  // Series terms t, t^2, t^3 and t^3/6 in Q30.
  logic [25:0] e0_t, e1_t, e2_t;
  logic [21:0] e0_t2, e1_t2, e2_t2;
  logic [17:0] e1_t3;
  logic [15:0] e2_t3d6;
  logic        e0_sat, e1_sat, e2_sat, e3_sat;
  logic [30:0] e3_e;
  logic [51:0] p_t2;
  logic [47:0] p_t3;
  logic [37:0] p_t3d6;

  assign p_t2   = 52'(t0) * 52'(t0);
  assign p_t3   = 48'(e0_t2) * 48'(e0_t);
  assign p_t3d6 = 38'(e1_t3) * 38'(DIV6_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      e0_t    <= t0;
      e0_t2   <= 22'(p_t2 >> 30);
      e0_sat  <= div_sat;
      e1_t    <= e0_t;
      e1_t2   <= e0_t2;
      e1_t3   <= 18'(p_t3 >> 30);
      e1_sat  <= e0_sat;
      e2_t    <= e1_t;
      e2_t2   <= e1_t2;
      e2_t3d6 <= 16'(p_t3d6 >> DIV6_SHIFT);
      e2_sat  <= e1_sat;
      e3_e    <= 31'(Q30_ONE - 32'(e2_t) + 32'(e2_t2 >> 1) - 32'(e2_t3d6));
      e3_sat  <= e2_sat;
    end
  end

  // Eight squarings raise the series for a/256 to the power 256.
  logic [30:0] sq_e   [SQUARINGS];
  logic        sq_sat [SQUARINGS];

  for (genvar k = 0; k < SQUARINGS; k++) begin : g_sq
    logic [30:0] e_in;
    logic        sat_in;
    logic [61:0] prod;

    if (k == 0) begin : g_first
      assign e_in   = e3_e;
      assign sat_in = e3_sat;
    end else begin : g_next
      assign e_in   = sq_e[k-1];
      assign sat_in = sq_sat[k-1];
    end

    assign prod = 62'(e_in) * 62'(e_in) + Q30_HALF;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_e[k]   <= 31'(prod >> 30);
        sq_sat[k] <= sat_in;
      end
    end
  end

  // Round back to Q16.
  always_ff @(posedge clk) begin
    if (en) begin
      gval <= sq_sat[SQUARINGS-1] ? '0
            : 17'((32'(sq_e[SQUARINGS-1]) + Q14_HALF) >> 14);
    end
  end

endmodule

/* rtl/rgf_ratio.sv */
// Pipelined 8-bit quotient 255*val/amp with the clamped cases carried alongside.
module rgf_ratio import rgf_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  ratio_kind_t kind,
  input  logic [23:0] num,
  input  logic [16:0] den,
  output logic [7:0]  level
);

  logic [23:0] rem_q  [RATIO_STAGES-1];
  logic [16:0] den_q  [RATIO_STAGES-1];
  logic [7:0]  quo_q  [RATIO_STAGES];
  ratio_kind_t kind_q [RATIO_STAGES];

  for (genvar k = 0; k < RATIO_STAGES; k++) begin : g_step
    localparam int B = RATIO_STAGES - 1 - k;
    logic [23:0] rem_in;
    logic [16:0] den_in;
    logic [7:0]  quo_in;
    ratio_kind_t kind_in;
    logic [24:0] shifted;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign quo_in  = '0;
      assign kind_in = kind;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign kind_in = kind_q[k-1];
    end

    assign shifted = 25'(den_in) << B;
    assign ge      = 25'(rem_in) >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[k]  <= quo_in | (8'(ge) << B);
        kind_q[k] <= kind_in;
      end
    end

    if (k < RATIO_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge ? 24'(25'(rem_in) - shifted) : rem_in;
          den_q[k] <= den_in;
        end
      end
    end
  end

  // Pick the clamped value or the quotient.
  always_comb begin
    unique case (kind_q[RATIO_STAGES-1])
      KIND_ZERO: level = '0;
      KIND_FULL: level = 8'(OUT_MAX);
      KIND_DIV:  level = quo_q[RATIO_STAGES-1];
      default:   level = '0;
    endcase
  end

endmodule

/* rtl/rgf_checker.sv */
// Port-level checks of the texel unit and their binding to it.
module rgf_checker import rgf_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [7:0]             col,
  input logic [7:0]             row,
  input logic [3:0]             slice,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [7:0]             intensity,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [15:0]            cfg_data
);

  // Words taken in and not yet delivered.
  logic [7:0] outstanding;
  logic       took, gave;
  assign took = in_valid && in_ready;
  assign gave = out_valid && out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (took && !gave) begin
      outstanding <= outstanding + 8'd1;
    end else if (gave && !took) begin
      outstanding <= outstanding - 8'd1;
    end
  end

  // A word waiting at the output holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(intensity))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // No word appears that was not taken in.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 8'd0)
    else $error("output word without an input word");

  // Input stalls only behind a word waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing at the output");

endmodule

bind radial_gaussian_falloff_texel_unit rgf_checker u_checker (.*);

/* test/texel_intensity_checker.sv */
// Checker for the radial Gaussian falloff texel unit: predicts and compares intensities.
`timescale 1ns / 1ps

module texel_intensity_checker import rgf_pkg::*; #(
  parameter int TEX_WIDTH  = 256,
  parameter int TEX_HEIGHT = 256,
  parameter int TEX_DEPTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             col,
  input  logic [7:0]             row,
  input  logic [3:0]             slice,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [7:0]             intensity,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  output int                     fail_count,
  output int                     pending
);

  logic [15:0] offset_near_q, offset_far_q, sigma_near_q, sigma_far_q;
  logic [7:0]  expected_intensity[$];
  int          texel_seen;

  // Integer square root, floor, of a Q32 square.
  function automatic longint isqrt_floor(longint n);
    longint res;
    longint b;
    res = 0;
    b = 64'sh4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // exp(-a) for a in Q16: cubic series on a/256 in Q30, then eight squarings.
  function automatic longint neg_exp_q16(longint a);
    longint t, t2, t3, e;
    if (a >= 16 * 65536) return 0;
    t = a << 6;
    t2 = (t * t) >> 30;
    t3 = (t2 * t) >> 30;
    e = (64'sd1 << 30) - t + (t2 >> 1) - t3 / 6;
    for (int i = 0; i < 8; i++) e = (e * e + (64'sd1 << 29)) >> 30;
    return (e + (64'sd1 << 13)) >> 14;
  endfunction

  function automatic longint gauss_q16(longint d, longint s);
    longint mag;
    mag = (d < 0) ? -d : d;
    return neg_exp_q16(((mag * mag) << 16) / (2 * s * s));
  endfunction

  function automatic longint slice_lerp(longint lo, longint hi, longint w);
    return (lo * (TEX_DEPTH - 1 - w) + hi * w) / (TEX_DEPTH - 1);
  endfunction

  // Index saturated to the volume and mapped to signed Q16 in [-1,1].
  function automatic longint centred_coord(longint idx, longint dim);
    if (idx > dim - 1) idx = dim - 1;
    return (2 * idx * 65536) / (dim - 1) - 65536;
  endfunction

  function automatic logic [7:0] falloff_intensity(logic [7:0] c, logic [7:0] r_idx,
                                                   logic [3:0] s_idx);
    longint w, off, sig, x, y, rad, bias, amp, val, res;
    w = s_idx;
    if (w > TEX_DEPTH - 1) w = TEX_DEPTH - 1;
    off = slice_lerp(offset_near_q, offset_far_q, w);
    sig = slice_lerp(sigma_near_q, sigma_far_q, w);
    x = centred_coord(c, TEX_WIDTH);
    y = centred_coord(r_idx, TEX_HEIGHT);
    rad = isqrt_floor(x * x + y * y);
    res = 0;
    if (sig != 0) begin
      bias = gauss_q16(65536 - off, sig);
      amp = gauss_q16(off, sig) - bias;
      if (amp > 0) begin
        val = gauss_q16(rad - off, sig) - bias;
        if (val >= amp) res = 255;
        else if (val > 0) res = (255 * val) / amp;
      end
    end
    return res[7:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count = fail_count + 1;
  endtask

  // Track register writes, predict each accepted texel word and check each result word.
  always @(posedge clk) begin
    if (rst) begin
      offset_near_q <= RST_OFFSET_NEAR;
      offset_far_q  <= RST_OFFSET_FAR;
      sigma_near_q  <= RST_SIGMA_NEAR;
      sigma_far_q   <= RST_SIGMA_FAR;
      expected_intensity.delete();
      texel_seen = 0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFFSET_NEAR: offset_near_q <= cfg_data;
          REG_OFFSET_FAR:  offset_far_q  <= cfg_data;
          REG_SIGMA_NEAR:  sigma_near_q  <= cfg_data;
          REG_SIGMA_FAR:   sigma_far_q   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_intensity.size() == 0) begin
          report_mismatch($sformatf("unexpected intensity word %0d", intensity));
        end else begin
          if (intensity !== expected_intensity[0])
            report_mismatch($sformatf("texel %0d intensity %0d, predicted %0d",
                                      texel_seen, intensity, expected_intensity[0]));
          void'(expected_intensity.pop_front());
          texel_seen = texel_seen + 1;
        end
      end
      if (in_valid && in_ready)
        expected_intensity.push_back(falloff_intensity(col, row, slice));
    end
    pending <= expected_intensity.size();
  end

endmodule

/* test/radial_gaussian_falloff_texel_unit_tb.sv */
// Testbench top: drives texel and register words into the texel unit and gives the verdict.
`timescale 1ns / 1ps

module radial_gaussian_falloff_texel_unit_tb import rgf_pkg::*;;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             col = '0;
  logic [7:0]             row = '0;
  logic [3:0]             slice = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             intensity;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;
  int                     fail_count;
  int                     pending;
  bit                     burst_mode = 1'b0;

  always #5 clk = ~clk;

  radial_gaussian_falloff_texel_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .col(col), .row(row), .slice(slice),
    .out_valid(out_valid), .out_ready(out_ready), .intensity(intensity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  texel_intensity_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .col(col), .row(row), .slice(slice),
    .out_valid(out_valid), .out_ready(out_ready), .intensity(intensity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Gap length: mostly short, a few long, none during a burst.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (burst_mode || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one texel word and hold it until it is taken.
  task automatic send_texel(logic [7:0] c, logic [7:0] r, logic [3:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    col <= c;
    row <= r;
    slice <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One register word, then the channel idles before the task returns.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let the pipeline drain completely before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_regs(logic [15:0] on, logic [15:0] of, logic [15:0] sn, logic [15:0] sf);
    write_reg(REG_OFFSET_NEAR, on);
    write_reg(REG_OFFSET_FAR, of);
    write_reg(REG_SIGMA_NEAR, sn);
    write_reg(REG_SIGMA_FAR, sf);
  endtask

  task automatic random_texels(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) burst_mode = ~burst_mode;
      send_texel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 4'($urandom_range(0, 15)));
    end
    burst_mode = 1'b0;
  endtask

  // Result side: ready held for random stretches, occasionally stalled long.
  initial begin
    int hold;
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      out_ready <= ($urandom_range(0, 3) != 0);
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed texels with the reset registers: corners, edges, centre, both end slices.
    send_texel(8'd0, 8'd0, 4'd0);
    send_texel(8'd255, 8'd255, 4'd15);
    send_texel(8'd127, 8'd128, 4'd0);
    send_texel(8'd128, 8'd127, 4'd15);
    send_texel(8'd128, 8'd128, 4'd7);
    send_texel(8'd0, 8'd255, 4'd8);
    send_texel(8'd255, 8'd0, 4'd1);
    send_texel(8'd134, 8'd128, 4'd0);
    send_texel(8'd153, 8'd128, 4'd15);
    send_texel(8'd170, 8'd85, 4'd10);
    drain();

    // Peak not positive: ring radius past the middle.
    load_regs(16'd65535, 16'd40000, 16'd2000, 16'd9000);
    write_reg(8'd200, 16'hFFFF);
    send_texel(8'd0, 8'd0, 4'd0);
    send_texel(8'd128, 8'd128, 4'd15);
    send_texel(8'd200, 8'd10, 4'd5);
    drain();

    // Zero sigma at the near end and tiny sigma that interpolates to zero.
    load_regs(16'd0, 16'd65535, 16'd0, 16'd1);
    send_texel(8'd128, 8'd128, 4'd0);
    send_texel(8'd128, 8'd128, 4'd1);
    send_texel(8'd255, 8'd255, 4'd15);
    send_texel(8'd0, 8'd128, 4'd14);
    drain();

    // Register extremes, the reset values, then random settings, each with a random batch.
    load_regs(16'd0, 16'd0, 16'd65535, 16'd65535);
    random_texels(110);
    drain();
    load_regs(16'd65535, 16'd65535, 16'd1, 16'd1);
    random_texels(60);
    drain();
    load_regs(16'd3277, 16'd13107, 16'd1311, 16'd32768);
    random_texels(150);
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      load_regs(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(1, 65535)), 16'($urandom_range(500, 40000)));
      if ($urandom_range(0, 1))
        write_reg(CFG_INDEX_W'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));
      random_texels(120);
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rgf_pkg.sv
rtl/rgf_delay.sv
rtl/rgf_isqrt.sv
rtl/rgf_gauss.sv
rtl/rgf_ratio.sv
rtl/radial_gaussian_falloff_texel_unit.sv
rtl/rgf_checker.sv
test/texel_intensity_checker.sv
test/radial_gaussian_falloff_texel_unit_tb.sv
